>>> rtl/mpvpr_pkg.sv
// Package for the mains peak voltage protection relay.
// Holds the field widths, fixed limits, register codes and reset values.
// No dependencies.
package mpvpr_pkg;

    // Field widths
    localparam int SAMPLE_W    = 10;
    localparam int VOLT_W      = 10;
    localparam int UPPER_W     = 9;
    localparam int LOWER_W     = 8;
    localparam int DELAY_W     = 10;
    localparam int SCALE_W     = 10;
    localparam int COUNT_W     = 8;
    localparam int DROPOUT_W   = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int PROD_W      = SAMPLE_W + SCALE_W;

    // Parameter defaults
    localparam int ADC_BITS_DEFAULT         = 10;
    localparam int TICKS_PER_SECOND_DEFAULT = 92;

    // Waveform tracking limits
    localparam logic [SAMPLE_W-1:0] NOISE_LEVEL  = 10'd5;
    localparam logic [COUNT_W-1:0]  MIN_POSITIVE = 8'd5;
    localparam logic [COUNT_W-1:0]  HALFWAVE_END = 8'd20;
    localparam logic [COUNT_W-1:0]  FAULT_COUNT  = 8'd200;

    // Protection limits
    localparam logic [VOLT_W-1:0]    FAST_LIMIT    = 10'd120;
    localparam logic [VOLT_W-1:0]    VOLT_MAX      = 10'd1023;
    localparam logic [DROPOUT_W-1:0] DROPOUT_TICKS = 7'd100;

    // Divide by 1000 as multiply by ceil(2^30 / 1000), exact below 2^20
    localparam int                 RECIP_W     = 21;
    localparam int                 RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_1000  = 21'd1073742;
    localparam int                 QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

    // Register reset values
    localparam logic [UPPER_W-1:0] UPPER_RESET = 9'd250;
    localparam logic [LOWER_W-1:0] LOWER_RESET = 8'd170;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd30;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd500;

    // Item kinds
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } t_command;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_UPPER = 2'd0,
        CFG_LOWER = 2'd1,
        CFG_DELAY = 2'd2,
        CFG_SCALE = 2'd3
    } t_cfg_index;

endpackage

>>> rtl/mains_peak_voltage_protection_relay.sv
// Mains peak voltage protection relay, top level.
// Uses mpvpr_pkg for widths, limits and register codes.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   i_command selects an ADC sample (i_adc_sample used) or a timer tick.
//   Every item gives exactly one result on the output channel
//   (o_out_valid / i_out_stall): relay state, line voltage, restart seconds
//   left, and a flag set when a sample closed a half-wave or found a fault.
//   Registers are written over i_cfg_valid / o_cfg_ready, index 0..3 being
//   upper threshold, lower threshold, restart delay and scale factor; the
//   port is always ready. Write only while no item is in flight.
// Timing
//   A result passes the product register between the scaling multiply
//   (peak times scale factor) and the reciprocal multiply that divides
//   by 1000, then the result register. One item is taken every cycle
//   while o_in_stall is low.
// Reset and stall
//   Synchronous active-low reset empties both stages, restores register
//   defaults and loads the restart timer with 30 s. A stalled result holds;
//   the stage before it keeps filling, and o_in_stall rises only once both
//   stages hold items.
module mains_peak_voltage_protection_relay #(
    parameter int ADC_BITS         = mpvpr_pkg::ADC_BITS_DEFAULT,
    parameter int TICKS_PER_SECOND = mpvpr_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [mpvpr_pkg::SAMPLE_W-1:0]      i_adc_sample,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_relay_on,
    output logic [mpvpr_pkg::VOLT_W-1:0]        o_line_voltage,
    output logic [mpvpr_pkg::DELAY_W-1:0]       o_restart_remaining,
    output logic                                o_measurement_done,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpvpr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mpvpr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW     = mpvpr_pkg::SAMPLE_W;
    localparam int PRE_W  = $clog2(TICKS_PER_SECOND);
    localparam logic [SW-1:0] SAMPLE_MASK =
        (ADC_BITS >= SW) ? {SW{1'b1}} : SW'((1 << ADC_BITS) - 1);
    localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(TICKS_PER_SECOND - 1);

    // Configuration registers
    logic [mpvpr_pkg::UPPER_W-1:0] r_upper;
    logic [mpvpr_pkg::LOWER_W-1:0] r_lower;
    logic [mpvpr_pkg::DELAY_W-1:0] r_delay;
    logic [mpvpr_pkg::SCALE_W-1:0] r_scale;

    // Waveform state (first stage)
    logic [SW-1:0]                 r_peak, n_peak;
    logic [mpvpr_pkg::COUNT_W-1:0] r_pos, n_pos;
    logic [mpvpr_pkg::COUNT_W-1:0] r_low, n_low;
    logic [SW-1:0]                 r_latched, n_latched;
    logic                          r_pending, n_pending;

    // First stage pipeline register
    logic                          r_a_valid;
    logic                          r_a_cmd;
    logic                          r_a_done, n_a_done;
    logic                          r_a_load, n_a_load;
    logic [mpvpr_pkg::PROD_W-1:0]  r_a_prod, n_a_prod;

    // Protection state (second stage)
    logic [mpvpr_pkg::VOLT_W-1:0]    r_volt, n_volt;
    logic [mpvpr_pkg::DELAY_W-1:0]   r_restart, n_restart;
    logic [mpvpr_pkg::DROPOUT_W-1:0] r_drop, n_drop;
    logic [PRE_W-1:0]                r_pre, n_pre;

    // Result register
    logic                          r_o_valid;
    logic                          r_o_relay;
    logic [mpvpr_pkg::VOLT_W-1:0]  r_o_volt;
    logic [mpvpr_pkg::DELAY_W-1:0] r_o_restart;
    logic                          r_o_done;

    // Stage enables
    logic en_out, en_a, a_fire, b_fire;
    logic [SW-1:0] sample;
    logic [mpvpr_pkg::COUNT_W-1:0] pos_inc, low_inc;
    logic [mpvpr_pkg::PROD_W+mpvpr_pkg::RECIP_W-1:0] quot_wide;
    logic [mpvpr_pkg::QUOT_W-1:0] quot;
    logic [mpvpr_pkg::VOLT_W-1:0] volt_now;
    logic mild_under;

    assign en_out = !r_o_valid || !i_out_stall;
    assign en_a   = !r_a_valid || en_out;
    assign a_fire = i_in_valid && en_a;
    assign b_fire = r_a_valid && en_out;

    assign o_in_stall  = !en_a;
    assign o_cfg_ready = 1'b1;

    // Track the half-wave and capture the scaled peak on a tick
    assign sample  = i_adc_sample & SAMPLE_MASK;
    assign pos_inc = r_pos + 1'b1;
    assign low_inc = r_low + 1'b1;

    always_comb begin
        n_peak    = r_peak;
        n_pos     = r_pos;
        n_low     = r_low;
        n_latched = r_latched;
        n_pending = r_pending;
        n_a_done  = 1'b0;
        n_a_load  = 1'b0;
        n_a_prod  = '0;
        if (a_fire) begin
            if (mpvpr_pkg::t_command'(i_command) == mpvpr_pkg::CMD_SAMPLE) begin
                if (sample > mpvpr_pkg::NOISE_LEVEL) begin
                    if (sample > r_peak) begin
                        n_peak = sample;
                    end
                    n_pos = pos_inc;
                    n_low = '0;
                    if (pos_inc > mpvpr_pkg::FAULT_COUNT) begin
                        n_a_done = 1'b1;
                        n_latched = '0;
                    end
                end else begin
                    n_low = low_inc;
                    if (low_inc > mpvpr_pkg::HALFWAVE_END &&
                        r_pos > mpvpr_pkg::MIN_POSITIVE) begin
                        n_a_done  = 1'b1;
                        n_latched = r_peak;
                    end
                    if (low_inc > mpvpr_pkg::FAULT_COUNT) begin
                        n_a_done  = 1'b1;
                        n_latched = '0;
                    end
                end
                // closing a half-wave or a fault restarts tracking
                if (n_a_done) begin
                    n_peak    = '0;
                    n_pos     = '0;
                    n_low     = '0;
                    n_pending = 1'b1;
                end
            end else if (r_pending) begin
                n_pending = 1'b0;
                n_a_load  = 1'b1;
                n_a_prod  = r_latched * r_scale;
            end
        end
    end

    // Divide by 1000 and saturate
    assign quot_wide = {{mpvpr_pkg::RECIP_W{1'b0}}, r_a_prod} *
                       {{mpvpr_pkg::PROD_W{1'b0}}, mpvpr_pkg::RECIP_1000};
    assign quot      = quot_wide[mpvpr_pkg::PROD_W+mpvpr_pkg::RECIP_W-1:
                                 mpvpr_pkg::RECIP_SHIFT];

    always_comb begin
        volt_now = r_volt;
        if (r_a_load) begin
            volt_now = (quot > mpvpr_pkg::QUOT_W'(mpvpr_pkg::VOLT_MAX)) ?
                       mpvpr_pkg::VOLT_MAX : quot[mpvpr_pkg::VOLT_W-1:0];
        end
    end

    assign mild_under = (volt_now < mpvpr_pkg::VOLT_W'(r_lower)) &&
                        (volt_now >= mpvpr_pkg::FAST_LIMIT);

    // Run the protection timers on a tick
    always_comb begin
        n_volt    = r_volt;
        n_restart = r_restart;
        n_drop    = r_drop;
        n_pre     = r_pre;
        if (b_fire && mpvpr_pkg::t_command'(r_a_cmd) == mpvpr_pkg::CMD_TICK) begin
            n_volt = volt_now;
            if (volt_now > mpvpr_pkg::VOLT_W'(r_upper) ||
                (volt_now < mpvpr_pkg::VOLT_W'(r_lower) &&
                 volt_now < mpvpr_pkg::FAST_LIMIT)) begin
                n_restart = r_delay;
            end
            if (mild_under) begin
                if (n_restart != '0) begin
                    n_drop = '0;
                end
                if (n_drop != '0) begin
                    n_drop = n_drop - 1'b1;
                end
            end else begin
                n_drop = mpvpr_pkg::DROPOUT_TICKS;
            end
            if (n_drop == '0) begin
                n_restart = r_delay;
            end
            if (r_pre >= PRE_LAST) begin
                n_pre = '0;
                if (n_restart != '0) begin
                    n_restart = n_restart - 1'b1;
                end
            end else begin
                n_pre = r_pre + 1'b1;
            end
        end
    end

    // Registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper   <= mpvpr_pkg::UPPER_RESET;
            r_lower   <= mpvpr_pkg::LOWER_RESET;
            r_delay   <= mpvpr_pkg::DELAY_RESET;
            r_scale   <= mpvpr_pkg::SCALE_RESET;
            r_peak    <= '0;
            r_pos     <= '0;
            r_low     <= '0;
            r_latched <= '0;
            r_pending <= 1'b0;
            r_a_valid <= 1'b0;
            r_volt    <= '0;
            r_restart <= mpvpr_pkg::DELAY_RESET;
            r_drop    <= '0;
            r_pre     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // take register writes
            if (i_cfg_valid) begin
                unique case (mpvpr_pkg::t_cfg_index'(i_cfg_index))
                    mpvpr_pkg::CFG_UPPER: r_upper <= i_cfg_data[mpvpr_pkg::UPPER_W-1:0];
                    mpvpr_pkg::CFG_LOWER: r_lower <= i_cfg_data[mpvpr_pkg::LOWER_W-1:0];
                    mpvpr_pkg::CFG_DELAY: r_delay <= i_cfg_data[mpvpr_pkg::DELAY_W-1:0];
                    mpvpr_pkg::CFG_SCALE: r_scale <= i_cfg_data[mpvpr_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
            r_peak    <= n_peak;
            r_pos     <= n_pos;
            r_low     <= n_low;
            r_latched <= n_latched;
            r_pending <= n_pending;
            r_volt    <= n_volt;
            r_restart <= n_restart;
            r_drop    <= n_drop;
            r_pre     <= n_pre;
            if (en_a) begin
                r_a_valid <= i_in_valid;
            end
            if (en_out) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // Payload registers: advance only with their stage
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_a_cmd  <= i_command;
            r_a_done <= n_a_done;
            r_a_load <= n_a_load;
            r_a_prod <= n_a_prod;
        end
        if (b_fire) begin
            r_o_relay   <= (n_restart == '0);
            r_o_volt    <= n_volt;
            r_o_restart <= n_restart;
            r_o_done    <= r_a_done;
        end
    end

    assign o_out_valid         = r_o_valid;
    assign o_relay_on          = r_o_relay;
    assign o_line_voltage      = r_o_volt;
    assign o_restart_remaining = r_o_restart;
    assign o_measurement_done  = r_o_done;

endmodule

>>> rtl/mpvpr_checker.sv
// Port checker for the mains peak voltage protection relay.
// Uses mpvpr_pkg for widths; bound to the top level at the end of this file.
module mpvpr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_relay_on,
    input logic [mpvpr_pkg::VOLT_W-1:0]      o_line_voltage,
    input logic [mpvpr_pkg::DELAY_W-1:0]     o_restart_remaining,
    input logic                              o_measurement_done
);

    // Relay closes exactly when the restart timer has run out
    a_relay_matches_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_relay_on == (o_restart_remaining == '0)))
        else $error("relay state disagrees with restart timer");

    // Hold a stalled result
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_relay_on) &&
            $stable(o_line_voltage) && $stable(o_restart_remaining) &&
            $stable(o_measurement_done))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An empty result register never pushes back on the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no result waiting");

endmodule

bind mains_peak_voltage_protection_relay mpvpr_checker u_mpvpr_checker (.*);

>>> test/tb.sv
// Self-checking testbench for mains_peak_voltage_protection_relay.
// Drives samples and ticks under random bursts and output stalls, predicts every result
// in-house and compares field by field. Depends on mpvpr_pkg and the relay top level.
module tb;

    // Field widths from the package
    localparam int SAMPLE_W    = mpvpr_pkg::SAMPLE_W;
    localparam int VOLT_W      = mpvpr_pkg::VOLT_W;
    localparam int DELAY_W     = mpvpr_pkg::DELAY_W;
    localparam int UPPER_W     = mpvpr_pkg::UPPER_W;
    localparam int LOWER_W     = mpvpr_pkg::LOWER_W;
    localparam int SCALE_W     = mpvpr_pkg::SCALE_W;
    localparam int COUNT_W     = mpvpr_pkg::COUNT_W;
    localparam int DROPOUT_W   = mpvpr_pkg::DROPOUT_W;
    localparam int PROD_W      = mpvpr_pkg::PROD_W;
    localparam int CFG_INDEX_W = mpvpr_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = mpvpr_pkg::CFG_DATA_W;

    // Behaviour limits used by the predictor
    localparam int SAMPLE_FLOOR  = 5;
    localparam int MIN_RISE      = 5;
    localparam int WAVE_GAP      = 20;
    localparam int STUCK_LIMIT   = 200;
    localparam int DIVISOR       = 1000;
    localparam int VOLT_TOP      = 1023;
    localparam int DEEP_SAG      = 120;
    localparam int SAG_HOLD      = 100;
    localparam int TICKS_PER_SEC = 92;

    localparam int NUM_PHASES   = 5;
    localparam int RANDOM_PHASE = 3;
    localparam int PHASE_ITEMS  = 360;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic               relay_on;
        logic [VOLT_W-1:0]  line_voltage;
        logic [DELAY_W-1:0] restart_remaining;
        logic               measurement_done;
    } t_relay_result;

    typedef struct packed {
        mpvpr_pkg::t_command cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [7:0]          count;
        logic                typed;
        t_relay_result       want;
    } t_stim_row;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] upper;
        logic [CFG_DATA_W-1:0] lower;
        logic [CFG_DATA_W-1:0] delay;
        logic [CFG_DATA_W-1:0] scale;
    } t_setting_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_mode;

    // Results that can be read straight off the behaviour after reset
    localparam t_relay_result QUIET_RESULT    = '{1'b0, 10'd0, 10'd30, 1'b0};
    localparam t_relay_result HALFWAVE_CLOSED = '{1'b0, 10'd0, 10'd30, 1'b1};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_command = 1'b0;
    logic [SAMPLE_W-1:0]    i_adc_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic                   o_relay_on;
    logic [VOLT_W-1:0]      o_line_voltage;
    logic [DELAY_W-1:0]     o_restart_remaining;
    logic                   o_measurement_done;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    mains_peak_voltage_protection_relay dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_command           (i_command),
        .i_adc_sample        (i_adc_sample),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_relay_on          (o_relay_on),
        .o_line_voltage      (o_line_voltage),
        .o_restart_remaining (o_restart_remaining),
        .o_measurement_done  (o_measurement_done),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted relay state and register copies, at reset values
    logic [UPPER_W-1:0]   cfg_upper = 9'd250;
    logic [LOWER_W-1:0]   cfg_lower = 8'd170;
    logic [DELAY_W-1:0]   cfg_delay = 10'd30;
    logic [SCALE_W-1:0]   cfg_scale = 10'd500;
    logic [SAMPLE_W-1:0]  peak_run = '0;
    logic [COUNT_W-1:0]   pos_cnt = '0;
    logic [COUNT_W-1:0]   low_cnt = '0;
    logic [SAMPLE_W-1:0]  peak_held = '0;
    logic                 peak_fresh = 1'b0;
    logic [VOLT_W-1:0]    volts_now = '0;
    logic [DELAY_W-1:0]   restart_secs = 10'd30;
    logic [DROPOUT_W-1:0] sag_ticks = '0;
    logic [6:0]           tick_phase = '0;

    t_relay_result awaited_results [$];
    t_relay_result oldest_result;
    int unsigned   mismatches = 0;
    int unsigned   items_in_phase = 0;
    int unsigned   burst_left = 10;
    bit            sender_gaps = 1'b1;
    bit            in_driving = 1'b0;
    logic [SAMPLE_W-1:0] band_peak = 10'd400;

    t_stim_row directed_rows [8] = '{
        '{mpvpr_pkg::CMD_TICK,   10'd0,    8'd1,  1'b1, QUIET_RESULT},
        '{mpvpr_pkg::CMD_SAMPLE, 10'd0,    8'd1,  1'b1, QUIET_RESULT},
        '{mpvpr_pkg::CMD_SAMPLE, 10'd5,    8'd1,  1'b1, QUIET_RESULT},
        '{mpvpr_pkg::CMD_SAMPLE, 10'd1023, 8'd1,  1'b1, QUIET_RESULT},
        '{mpvpr_pkg::CMD_SAMPLE, 10'd6,    8'd5,  1'b1, QUIET_RESULT},
        '{mpvpr_pkg::CMD_SAMPLE, 10'd0,    8'd20, 1'b1, QUIET_RESULT},
        '{mpvpr_pkg::CMD_SAMPLE, 10'd5,    8'd1,  1'b1, HALFWAVE_CLOSED},
        '{mpvpr_pkg::CMD_TICK,   10'd1023, 8'd2,  1'b0, '0}
    };

    // Low extremes, high extremes, beyond range, random, short delay
    t_setting_row phase_settings [NUM_PHASES] = '{
        '{10'd210, 10'd140, 10'd5,   10'd1},
        '{10'd290, 10'd200, 10'd995, 10'd999},
        '{10'd511, 10'd255, 10'd0,   10'd1023},
        '{10'd250, 10'd170, 10'd30,  10'd500},
        '{10'd250, 10'd170, 10'd1,   10'd500}
    };

    // Latch a half-wave result and restart the waveform tracking
    function automatic void close_measurement(input logic [SAMPLE_W-1:0] value);
        peak_held  = value;
        peak_run   = '0;
        pos_cnt    = '0;
        low_cnt    = '0;
        peak_fresh = 1'b1;
    endfunction

    function automatic t_relay_result compute_relay_result(
        input mpvpr_pkg::t_command cmd, input logic [SAMPLE_W-1:0] sample);
        t_relay_result     res;
        logic [PROD_W-1:0] scaled;
        logic [VOLT_W-1:0] v;
        int unsigned       quot;
        res = '0;
        if (cmd == mpvpr_pkg::CMD_SAMPLE) begin
            if (sample > SAMPLE_FLOOR) begin
                if (sample > peak_run) peak_run = sample;
                pos_cnt = pos_cnt + 1'b1;
                low_cnt = '0;
                if (pos_cnt > STUCK_LIMIT) begin
                    close_measurement('0);
                    res.measurement_done = 1'b1;
                end
            end else begin
                low_cnt = low_cnt + 1'b1;
                if (low_cnt > WAVE_GAP && pos_cnt > MIN_RISE) begin
                    close_measurement(peak_run);
                    res.measurement_done = 1'b1;
                end
                if (low_cnt > STUCK_LIMIT) begin
                    close_measurement('0);
                    res.measurement_done = 1'b1;
                end
            end
        end else begin
            // Convert a fresh peak to volts, saturating
            if (peak_fresh) begin
                peak_fresh = 1'b0;
                scaled = peak_held * cfg_scale;
                quot = scaled / DIVISOR;
                volts_now = (quot > VOLT_TOP) ? VOLT_W'(VOLT_TOP) : VOLT_W'(quot);
            end
            v = volts_now;
            if (v > cfg_upper || (v < cfg_lower && v < DEEP_SAG)) restart_secs = cfg_delay;
            // Mild sag rearms only once it has lasted the hold time
            if (v < cfg_lower && v >= DEEP_SAG) begin
                if (restart_secs != 0) sag_ticks = '0;
                if (sag_ticks != 0) sag_ticks = sag_ticks - 1'b1;
            end else begin
                sag_ticks = DROPOUT_W'(SAG_HOLD);
            end
            if (sag_ticks == 0) restart_secs = cfg_delay;
            // Count the restart timer down once a second
            if (tick_phase >= TICKS_PER_SEC - 1) begin
                tick_phase = '0;
                if (restart_secs != 0) restart_secs = restart_secs - 1'b1;
            end else begin
                tick_phase = tick_phase + 1'b1;
            end
        end
        res.relay_on          = (restart_secs == 0);
        res.line_voltage      = volts_now;
        res.restart_remaining = restart_secs;
        return res;
    endfunction

    // Choose a peak that lands the voltage in a random protection band
    function automatic logic [SAMPLE_W-1:0] pick_band_peak();
        int r;
        int lo;
        int hi;
        int target;
        int pk;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            lo = int'(cfg_lower);
            hi = int'(cfg_upper);
        end else if (r < 7) begin
            lo = DEEP_SAG;
            hi = int'(cfg_lower) - 1;
        end else if (r < 8) begin
            lo = 0;
            hi = DEEP_SAG - 1;
        end else begin
            lo = int'(cfg_upper) + 1;
            hi = VOLT_TOP;
        end
        if (hi < lo) hi = lo;
        target = $urandom_range(hi, lo);
        if (cfg_scale == 0) pk = $urandom_range(SAMPLE_FLOOR + 1, VOLT_TOP);
        else pk = (target * DIVISOR + int'(cfg_scale) - 1) / int'(cfg_scale);
        if (pk > VOLT_TOP) pk = VOLT_TOP;
        if (pk <= SAMPLE_FLOOR) pk = SAMPLE_FLOOR + 1;
        return SAMPLE_W'(pk);
    endfunction

    task automatic drop_valid();
        if (in_driving) begin
            i_in_valid <= 1'b0;
            in_driving = 1'b0;
        end
    endtask

    // Offer one item, wait for it to be taken, then record what it should produce
    task automatic send_item(input mpvpr_pkg::t_command cmd,
                             input logic [SAMPLE_W-1:0] sample,
                             input bit typed = 1'b0, input t_relay_result want = '0);
        t_relay_result predicted;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_adc_sample <= sample;
        in_driving = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = compute_relay_result(cmd, sample);
        awaited_results.push_back(typed ? want : predicted);
        items_in_phase++;
        // Once the burst runs out, close it and, with sender gaps on, idle for a while
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            if (sender_gaps) begin
                drop_valid();
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic write_setting(input mpvpr_pkg::t_cfg_index idx,
                                 input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            mpvpr_pkg::CFG_UPPER: cfg_upper = data[UPPER_W-1:0];
            mpvpr_pkg::CFG_LOWER: cfg_lower = data[LOWER_W-1:0];
            mpvpr_pkg::CFG_DELAY: cfg_delay = data[DELAY_W-1:0];
            mpvpr_pkg::CFG_SCALE: cfg_scale = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Stall the result channel in modes that change every so often
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned stall_span = 64;
    logic [2:0]  stall_tick = '0;

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
            stall_span <= $urandom_range(32, 256);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: i_out_stall <= (stall_tick >= 3'd5);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result item arrived with nothing awaited");
                mismatches++;
            end else begin
                oldest_result = awaited_results.pop_front();
                if (o_relay_on !== oldest_result.relay_on) begin
                    $error("relay_on: expected %0d, got %0d",
                           oldest_result.relay_on, o_relay_on);
                    mismatches++;
                end
                if (o_line_voltage !== oldest_result.line_voltage) begin
                    $error("line_voltage: expected %0d, got %0d",
                           oldest_result.line_voltage, o_line_voltage);
                    mismatches++;
                end
                if (o_restart_remaining !== oldest_result.restart_remaining) begin
                    $error("restart_remaining: expected %0d, got %0d",
                           oldest_result.restart_remaining, o_restart_remaining);
                    mismatches++;
                end
                if (o_measurement_done !== oldest_result.measurement_done) begin
                    $error("measurement_done: expected %0d, got %0d",
                           oldest_result.measurement_done, o_measurement_done);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    int unsigned run_cycles = 0;

    always @(posedge i_clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles >= CYCLE_LIMIT) begin
            $error("run timed out with %0d results outstanding", awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned row;
        int unsigned k;
        int unsigned phase;
        int unsigned pick;
        int unsigned pos_len;
        int unsigned low_len;
        int unsigned spot;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (row = 0; row < $size(directed_rows); row++) begin
            for (k = 0; k < directed_rows[row].count; k++) begin
                send_item(directed_rows[row].cmd, directed_rows[row].sample,
                          directed_rows[row].typed, directed_rows[row].want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // Hold off register writes until the block has drained
            drop_valid();
            while (awaited_results.size() != 0) @(posedge i_clk);
            if (phase == RANDOM_PHASE) begin
                phase_settings[phase].upper = CFG_DATA_W'($urandom_range(210, 290));
                phase_settings[phase].lower = CFG_DATA_W'($urandom_range(140, 200));
                phase_settings[phase].delay = CFG_DATA_W'($urandom_range(5, 995));
                phase_settings[phase].scale = CFG_DATA_W'($urandom_range(1, 999));
            end
            write_setting(mpvpr_pkg::CFG_UPPER, phase_settings[phase].upper);
            write_setting(mpvpr_pkg::CFG_LOWER, phase_settings[phase].lower);
            write_setting(mpvpr_pkg::CFG_DELAY, phase_settings[phase].delay);
            write_setting(mpvpr_pkg::CFG_SCALE, phase_settings[phase].scale);
            i_cfg_valid <= 1'b0;

            sender_gaps = ($urandom_range(0, 3) != 0);
            band_peak = pick_band_peak();
            items_in_phase = 0;
            while (items_in_phase < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    // Clean half-wave, then a few ticks
                    if ($urandom_range(0, 4) == 0) band_peak = pick_band_peak();
                    pos_len = $urandom_range(6, 14);
                    spot = $urandom_range(0, pos_len - 1);
                    for (k = 0; k < pos_len; k++) begin
                        send_item(mpvpr_pkg::CMD_SAMPLE, (k == spot) ? band_peak :
                                  SAMPLE_W'($urandom_range(SAMPLE_FLOOR + 1, band_peak)));
                    end
                    low_len = $urandom_range(21, 24);
                    for (k = 0; k < low_len; k++) begin
                        send_item(mpvpr_pkg::CMD_SAMPLE,
                                  SAMPLE_W'($urandom_range(0, SAMPLE_FLOOR)));
                    end
                    repeat ($urandom_range(0, 4)) begin
                        send_item(mpvpr_pkg::CMD_TICK, SAMPLE_W'($urandom()));
                    end
                end else if (pick < 70) begin
                    // Run of ticks so the timers can move
                    repeat ($urandom_range(20, 120)) begin
                        send_item(mpvpr_pkg::CMD_TICK, SAMPLE_W'($urandom()));
                    end
                end else if (pick < 82) begin
                    // Broken half-wave: too few positives or too short a gap
                    pos_len = $urandom_range(0, 14);
                    for (k = 0; k < pos_len; k++) begin
                        send_item(mpvpr_pkg::CMD_SAMPLE,
                                  SAMPLE_W'($urandom_range(SAMPLE_FLOOR + 1, VOLT_TOP)));
                    end
                    low_len = $urandom_range(0, WAVE_GAP);
                    for (k = 0; k < low_len; k++) begin
                        send_item(mpvpr_pkg::CMD_SAMPLE,
                                  SAMPLE_W'($urandom_range(0, SAMPLE_FLOOR)));
                    end
                end else if (pick < 86) begin
                    // Stuck-high waveform
                    repeat ($urandom_range(STUCK_LIMIT + 1, STUCK_LIMIT + 4)) begin
                        send_item(mpvpr_pkg::CMD_SAMPLE,
                                  SAMPLE_W'($urandom_range(SAMPLE_FLOOR + 1, VOLT_TOP)));
                    end
                end else if (pick < 90) begin
                    // Missing waveform
                    repeat ($urandom_range(STUCK_LIMIT + 1, STUCK_LIMIT + 4)) begin
                        send_item(mpvpr_pkg::CMD_SAMPLE,
                                  SAMPLE_W'($urandom_range(0, SAMPLE_FLOOR)));
                    end
                end else begin
                    // Noise: any kind, any value
                    repeat ($urandom_range(1, 12)) begin
                        send_item(mpvpr_pkg::t_command'($urandom_range(0, 1)),
                                  SAMPLE_W'($urandom()));
                    end
                end
            end
        end

        drop_valid();
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
